/* hdl/xs128_pkg.sv */
// xs128_pkg: shared types and constants for the xorshift128 range random core.
// No dependencies; used by xs128_ctrl, xs128_dp and the top level.
package xs128_pkg;

	localparam logic [31:0] MARKER_WORD = 32'h1234_5678;
	localparam logic [31:0] GEN_Y_INIT  = 32'd362436069;
	localparam logic [31:0] GEN_Z_INIT  = 32'd521288629;
	localparam logic [31:0] GEN_W_INIT  = 32'd88675123;

	localparam logic [6:0]  SCALE_FACTOR = 7'd100;
	localparam logic [24:0] BYTE_RANGE   = 25'd255;

	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
	localparam logic [31:0] RECIP_100   = 32'd1374389535;
	localparam int          RECIP_SHIFT = 37;

	localparam int DIV_STEPS = 32;
	localparam int BYTE_DRAWS = 4;

	typedef enum logic [1:0] {
		CMD_SCALED  = 2'd0,
		CMD_BOUNDED = 2'd1,
		CMD_BYTES   = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic load_in;
		logic load_span;
		logic step;
		logic div_step;
		logic mul;
		logic acc;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic equal;
		logic bytes;
	} dp_status_t;

endpackage

/* hdl/xs128_ctrl.sv */
// xs128_ctrl: sequencer for draw requests (check, step, divide, scale, pack, output).
// Depends on xs128_pkg; drives xs128_dp through dp_cmd_t.
module xs128_ctrl
	import xs128_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_STEP,
		S_DIV,
		S_MUL,
		S_ACC,
		S_OUT
	} state_t;

	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int DRAW_CNT_W = $clog2(BYTE_DRAWS);

	state_t                  state_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic [DRAW_CNT_W-1:0]   draw_cnt_q;
	logic                    m_tvalid_q;
	logic                    out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd           = '0;
		cmd.load_in   = (state_q == S_IDLE) && s_tvalid;
		cmd.load_span = (state_q == S_CHECK);
		cmd.step      = (state_q == S_STEP);
		cmd.div_step  = (state_q == S_DIV);
		cmd.mul       = (state_q == S_MUL);
		cmd.acc       = (state_q == S_ACC);
		cmd.load_out  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			div_cnt_q  <= '0;
			draw_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					draw_cnt_q <= '0;
					if (status.bad || status.equal)
						state_q <= S_OUT;
					else
						state_q <= S_STEP;
				end
				S_STEP: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (status.bytes && draw_cnt_q != DRAW_CNT_W'(BYTE_DRAWS - 1)) begin
						draw_cnt_q <= draw_cnt_q + 1'b1;
						state_q    <= S_STEP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/xs128_dp.sv */
// xs128_dp: generator state words, seed register, restoring divider, /100 scaling,
// result packing and output register. Depends on xs128_pkg; driven by xs128_ctrl.
module xs128_dp
	import xs128_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_data,
	input  logic [1:0]  in_cmd,
	input  logic [24:0] in_range_value,
	input  logic [23:0] in_min_value,
	input  logic [23:0] in_max_value,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic [31:0] random_value,
	output logic        error
);

	logic [31:0] seed_q;
	logic [31:0] gen_x_q, gen_y_q, gen_z_q, gen_w_q;
	cmd_code_t   cmd_q;
	logic [24:0] range_q;
	logic [23:0] min_q, max_q;
	logic [31:0] span_q;
	logic [31:0] rem_q, dvd_q;
	logic [63:0] prod_q;
	logic [31:0] acc_q;
	logic [31:0] out_value_q;
	logic        out_error_q;

	logic [24:0] draw_range;
	logic [31:0] x_src, t_word, w_next;
	logic [32:0] rem_sh, rem_diff;
	logic [26:0] quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= '0;
		else if (seed_we)
			seed_q <= seed_data;
	end

	assign status.bad   = (cmd_q == CMD_SCALED  && range_q == '0) ||
	                      (cmd_q == CMD_BOUNDED && max_q < min_q) ||
	                      (cmd_q == CMD_UNUSED);
	assign status.equal = (cmd_q == CMD_BOUNDED) && (max_q == min_q);
	assign status.bytes = (cmd_q == CMD_BYTES);

	always_comb begin
		case (cmd_q)
			CMD_BOUNDED: draw_range = {1'b0, max_q - min_q} + 25'd1;
			CMD_BYTES:   draw_range = BYTE_RANGE;
			default:     draw_range = range_q;
		endcase
	end

	assign x_src  = (gen_x_q == MARKER_WORD) ? seed_q : gen_x_q;
	assign t_word = x_src ^ (x_src << 11);
	assign w_next = gen_w_q ^ (gen_w_q >> 19) ^ t_word ^ (t_word >> 8);

	assign rem_sh   = {rem_q, dvd_q[31]};
	assign rem_diff = rem_sh - {1'b0, span_q};
	assign quot     = prod_q[63:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_x_q <= MARKER_WORD;
			gen_y_q <= GEN_Y_INIT;
			gen_z_q <= GEN_Z_INIT;
			gen_w_q <= GEN_W_INIT;
		end else if (cmd.step) begin
			gen_x_q <= gen_y_q;
			gen_y_q <= gen_z_q;
			gen_z_q <= gen_w_q;
			gen_w_q <= w_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= cmd_code_t'(in_cmd);
			range_q <= in_range_value;
			min_q   <= in_min_value;
			max_q   <= in_max_value;
		end
		if (cmd.load_span)
			span_q <= 32'(draw_range) * 32'(SCALE_FACTOR);
		if (cmd.step) begin
			rem_q <= '0;
			dvd_q <= w_next;
		end else if (cmd.div_step) begin
			rem_q <= rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
		if (cmd.mul)
			prod_q <= rem_q * RECIP_100;
		if (cmd.acc) begin
			case (cmd_q)
				CMD_BYTES:   acc_q <= {quot[7:0], acc_q[31:8]};
				CMD_BOUNDED: acc_q <= {8'b0, min_q} + {5'b0, quot};
				default:     acc_q <= {5'b0, quot};
			endcase
		end
		if (cmd.load_out) begin
			if (status.bad) begin
				out_value_q <= '0;
				out_error_q <= 1'b1;
			end else if (status.equal) begin
				out_value_q <= {8'b0, min_q};
				out_error_q <= 1'b0;
			end else begin
				out_value_q <= acc_q;
				out_error_q <= 1'b0;
			end
		end
	end

	assign random_value = out_value_q;
	assign error        = out_error_q;

endmodule

/* hdl/xorshift128_range_random_core.sv */
// xorshift128_range_random_core: top level joining xs128_ctrl and xs128_dp.
// Depends on xs128_pkg, xs128_ctrl and xs128_dp.
//
//   channel   signals                          transfer when
//   s_*       s_tvalid s_tready s_tdata[79:0]  s_tvalid && s_tready
//   m_*       m_tvalid m_tready m_tdata m_tuser m_tvalid && m_tready
//   cfg_*     cfg_valid cfg_ready cfg_data     cfg_valid && cfg_ready
//
// Each draw runs step, divide, scale and accumulate; the divide is done by the
// one-bit-per-cycle restoring divider. cmd 0/1 make one draw per request;
// cmd 2 makes four draws; rejected or equal-bound requests go straight to output.
// One request is in flight at a time; the next is taken once the result is registered.
// A result waiting on m_tready stalls only the final output load.
// Reset is asynchronous; no clearing pass.
module xorshift128_range_random_core
	import xs128_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // cmd[1:0], range_value[26:2], min_value[50:27],
	                               // max_value[74:51], zero pad[79:75]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // random_value[31:0]
	output logic        m_tuser,   // error[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // seed_value
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	xs128_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	xs128_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.seed_we        (cfg_valid && cfg_ready),
		.seed_data      (cfg_data),
		.in_cmd         (s_tdata[1:0]),
		.in_range_value (s_tdata[26:2]),
		.in_min_value   (s_tdata[50:27]),
		.in_max_value   (s_tdata[74:51]),
		.cmd            (dp_cmd),
		.status         (dp_status),
		.random_value   (m_tdata),
		.error          (m_tuser)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result carries nonzero data");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a request is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("pending result overwritten");

endmodule
